// ===== rtl/sfc_pkg.sv =====
`timescale 1ns / 1ps
// sfc_pkg: shared widths, plane type and relation codes for the sphere/frustum classifier.
// No dependencies.
package sfc_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_WIDTH     = 16;
	localparam int OFFSET_WIDTH     = 16;
	localparam int RADIUS_WIDTH     = COORD_WIDTH - 1;
	localparam int PLANE_COUNT      = 6;
	localparam int PLANE_WIDTH      = 3 * NORMAL_WIDTH + OFFSET_WIDTH;
	localparam int CFG_INDEX_WIDTH  = 3;

	localparam int PROD_WIDTH   = COORD_WIDTH + NORMAL_WIDTH;
	localparam int OFFS_SCALED  = OFFSET_WIDTH + NORMAL_FRAC_BITS;
	localparam int RAD_SCALED   = RADIUS_WIDTH + NORMAL_FRAC_BITS + 1;
	localparam int WIDE_TERM    = (PROD_WIDTH > OFFS_SCALED) ? PROD_WIDTH : OFFS_SCALED;
	localparam int WIDEST       = (WIDE_TERM > RAD_SCALED) ? WIDE_TERM : RAD_SCALED;
	localparam int DIST_WIDTH   = WIDEST + 2;

	typedef logic [PLANE_WIDTH-1:0] plane_t;

	typedef enum logic [1:0] {
		REL_INSIDE  = 2'd0,
		REL_PARTLY  = 2'd1,
		REL_OUTSIDE = 2'd2
	} relation_t;

	typedef struct packed {
		logic outside;
		logic partly;
	} plane_flags_t;

endpackage

// ===== rtl/sfc_plane_regs.sv =====
`timescale 1ns / 1ps
// sfc_plane_regs: configuration file holding the six frustum planes.
// Depends on sfc_pkg.
module sfc_plane_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [sfc_pkg::PLANE_WIDTH-1:0]     cfg_data,
	output sfc_pkg::plane_t                     planes [sfc_pkg::PLANE_COUNT]
);
	import sfc_pkg::*;

	plane_t plane_q [PLANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we) begin
			// indexes past the last plane are dropped
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (cfg_index == CFG_INDEX_WIDTH'(i)) begin
					plane_q[i] <= cfg_data;
				end
			end
		end
	end

	assign planes = plane_q;

endmodule

// ===== rtl/sfc_plane_unit.sv =====
`timescale 1ns / 1ps
// sfc_plane_unit: three-stage signed distance and radius compare for one plane.
// Depends on sfc_pkg.
module sfc_plane_unit (
	input  logic                                   clk,
	input  sfc_pkg::plane_t                        plane,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_z,
	input  logic [sfc_pkg::RADIUS_WIDTH-1:0]       radius_s2,
	output sfc_pkg::plane_flags_t                  flags_s3
);
	import sfc_pkg::*;

	logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
	logic signed [OFFSET_WIDTH-1:0] offset;
	logic signed [PROD_WIDTH-1:0]   px_s1, py_s1, pz_s1;
	logic signed [DIST_WIDTH-1:0]   dist_s2;
	logic signed [DIST_WIDTH-1:0]   rs;
	plane_flags_t                   flags_s3_r;

	assign nx     = plane[NORMAL_WIDTH-1:0];
	assign ny     = plane[2*NORMAL_WIDTH-1:NORMAL_WIDTH];
	assign nz     = plane[3*NORMAL_WIDTH-1:2*NORMAL_WIDTH];
	assign offset = plane[PLANE_WIDTH-1:3*NORMAL_WIDTH];

	assign rs = DIST_WIDTH'({1'b0, radius_s2}) <<< NORMAL_FRAC_BITS;

	always_ff @(posedge clk) begin
		px_s1 <= PROD_WIDTH'(nx) * PROD_WIDTH'(center_x);
		py_s1 <= PROD_WIDTH'(ny) * PROD_WIDTH'(center_y);
		pz_s1 <= PROD_WIDTH'(nz) * PROD_WIDTH'(center_z);

		// the user must keep offset stable while items are in flight; this block does not enforce it
		dist_s2 <= DIST_WIDTH'(px_s1) + DIST_WIDTH'(py_s1) + DIST_WIDTH'(pz_s1)
			+ (DIST_WIDTH'(offset) <<< NORMAL_FRAC_BITS);

		flags_s3_r.outside <= dist_s2 < -rs;
		flags_s3_r.partly  <= dist_s2 < rs;
	end

	assign flags_s3 = flags_s3_r;

endmodule

// ===== rtl/sphere_frustum_classifier.sv =====
`timescale 1ns / 1ps
// sphere_frustum_classifier: top level, six plane units and the result merge.
// Depends on sfc_pkg, sfc_plane_regs, sfc_plane_unit.
//
// Usage:
//   Planes are loaded through cfg_we / cfg_index / cfg_data, one 64-bit plane
//   per write, index 0..5; other indexes are ignored. Load only while idle.
//   A sphere transfer happens on every clock edge with start high and busy
//   low. busy is never raised, so a sphere can be issued every cycle.
//   Each sphere produces one relation, shown with done for one cycle after it
//   has passed through the multiply, sum, compare and merge registers in that
//   order.
//   Throughput is one sphere per cycle; results come out in issue order.
//   The receiver cannot stall: relation must be taken while done is high.
//   Reset clears all planes to zero and empties the pipeline.
module sphere_frustum_classifier (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_z,
	input  logic [sfc_pkg::RADIUS_WIDTH-1:0]       radius,
	output logic                                   done,
	output sfc_pkg::relation_t                     relation,
	input  logic                                   cfg_we,
	input  logic [sfc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [sfc_pkg::PLANE_WIDTH-1:0]        cfg_data
);
	import sfc_pkg::*;

	plane_t                  planes [PLANE_COUNT];
	plane_flags_t            flags_s3 [PLANE_COUNT];
	logic                    valid_s1, valid_s2, valid_s3;
	logic [RADIUS_WIDTH-1:0] radius_s1, radius_s2;
	logic                    any_outside, any_partly;
	logic                    done_q;
	relation_t               relation_q;

	assign busy = 1'b0;

	sfc_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
		sfc_plane_unit u_plane (
			.clk       (clk),
			.plane     (planes[g]),
			.center_x  (center_x),
			.center_y  (center_y),
			.center_z  (center_z),
			.radius_s2 (radius_s2),
			.flags_s3  (flags_s3[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		radius_s1 <= radius;
		radius_s2 <= radius_s1;
	end

	always_comb begin
		any_outside = 1'b0;
		any_partly  = 1'b0;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			any_outside = any_outside | flags_s3[i].outside;
			any_partly  = any_partly | flags_s3[i].partly;
		end
	end

	always_ff @(posedge clk) begin
		if (any_outside) begin
			relation_q <= REL_OUTSIDE;
		end else if (any_partly) begin
			relation_q <= REL_PARTLY;
		end else begin
			relation_q <= REL_INSIDE;
		end
	end

	assign done     = done_q;
	assign relation = relation_q;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("transfer without result four cycles later");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without matching transfer");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(radius == '0, 4) |-> relation != REL_PARTLY)
		else $error("zero radius sphere classified as partly inside");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for sphere_frustum_classifier; predicts each relation from its own
// copy of the six planes and checks results in issue order. Depends on sfc_pkg and the RTL top.
module tb;
	import sfc_pkg::*;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cz;
		logic [RADIUS_WIDTH-1:0]       rad;
	} sphere_t;

	typedef plane_t frustum_t [PLANE_COUNT];

	localparam logic [CFG_INDEX_WIDTH-1:0] IDX_UNUSED_LO = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] IDX_UNUSED_HI = 3'd7;
	localparam logic [15:0] NORM_ONE     = 16'h4000;
	localparam logic [15:0] NORM_NEG_ONE = 16'hC000;
	localparam logic [15:0] FIELD_MAX    = 16'h7FFF;
	localparam logic [15:0] FIELD_MIN    = 16'h8000;
	localparam int PIPE_SLACK = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_WIDTH-1:0] center_x = '0;
	logic signed [COORD_WIDTH-1:0] center_y = '0;
	logic signed [COORD_WIDTH-1:0] center_z = '0;
	logic [RADIUS_WIDTH-1:0] radius = '0;
	logic done;
	relation_t relation;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [PLANE_WIDTH-1:0] cfg_data = '0;

	sphere_frustum_classifier dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.center_x(center_x), .center_y(center_y), .center_z(center_z), .radius(radius),
		.done(done), .relation(relation),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frustum_t frustum = '{default: '0};
	sphere_t sphere_q[$];
	relation_t relation_q[$];
	logic took = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int errors = 0;
	int n_spheres = 0;
	int n_settings = 0;
	int n_rel[3] = '{0, 0, 0};

	function automatic relation_t classify_sphere(sphere_t s);
		longint sdist;
		longint rs;
		logic signed [15:0] nx, ny, nz, off;
		logic any_out;
		logic any_part;
		any_out = 1'b0;
		any_part = 1'b0;
		rs = longint'({1'b0, s.rad}) <<< NORMAL_FRAC_BITS;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			nx = frustum[i][15:0];
			ny = frustum[i][31:16];
			nz = frustum[i][47:32];
			off = frustum[i][63:48];
			sdist = longint'(nx) * longint'(s.cx) + longint'(ny) * longint'(s.cy)
				+ longint'(nz) * longint'(s.cz) + (longint'(off) <<< NORMAL_FRAC_BITS);
			if (sdist < -rs)
				any_out = 1'b1;
			else if (sdist < rs)
				any_part = 1'b1;
		end
		if (any_out)
			return REL_OUTSIDE;
		if (any_part)
			return REL_PARTLY;
		return REL_INSIDE;
	endfunction

	function automatic logic [15:0] rand_signed(int span);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic sphere_t rand_sphere(int span);
		sphere_t s;
		if ($urandom_range(0, 3) == 0) begin
			s.cx = 16'($urandom);
			s.cy = 16'($urandom);
			s.cz = 16'($urandom);
		end else begin
			s.cx = rand_signed(span);
			s.cy = rand_signed(span);
			s.cz = rand_signed(span);
		end
		case ($urandom_range(0, 7))
			0: s.rad = '0;
			1, 2: s.rad = 15'($urandom);
			default: s.rad = 15'($urandom_range(0, span));
		endcase
		return s;
	endfunction

	function automatic plane_t pack_plane(logic [15:0] nx, ny, nz, off);
		return {off, nz, ny, nx};
	endfunction

	function automatic frustum_t box_frustum(logic [15:0] w);
		frustum_t f;
		f[0] = pack_plane(NORM_ONE, '0, '0, w);
		f[1] = pack_plane(NORM_NEG_ONE, '0, '0, w);
		f[2] = pack_plane('0, NORM_ONE, '0, w);
		f[3] = pack_plane('0, NORM_NEG_ONE, '0, w);
		f[4] = pack_plane('0, '0, NORM_ONE, w);
		f[5] = pack_plane('0, '0, NORM_NEG_ONE, w);
		return f;
	endfunction

	function automatic frustum_t rand_frustum(int nspan, int ospan, logic wide);
		frustum_t f;
		for (int i = 0; i < PLANE_COUNT; i++)
			f[i] = wide ? {$urandom, $urandom}
				: pack_plane(rand_signed(nspan), rand_signed(nspan), rand_signed(nspan),
					rand_signed(ospan));
		return f;
	endfunction

	function automatic frustum_t flat_frustum(logic [15:0] v);
		frustum_t f;
		for (int i = 0; i < PLANE_COUNT; i++)
			f[i] = pack_plane(v, v, v, v);
		return f;
	endfunction

	task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input plane_t data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < PLANE_COUNT)
			frustum[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_frustum(input frustum_t f);
		for (int i = 0; i < PLANE_COUNT; i++)
			cfg_write(CFG_INDEX_WIDTH'(i), f[i]);
		n_settings++;
		@(posedge clk);
	endtask

	task automatic add_random(int n, int span);
		for (int k = 0; k < n; k++)
			sphere_q.push_back(rand_sphere(span));
	endtask

	task automatic add_sphere(int x, int y, int z, int r);
		sphere_t s;
		s.cx = 16'(x);
		s.cy = 16'(y);
		s.cz = 16'(z);
		s.rad = 15'(r);
		sphere_q.push_back(s);
	endtask

	// hold until every issued sphere is back, then flag anything left over
	task automatic settle();
		while (sphere_q.size() > 0 || start)
			@(posedge clk);
		for (int k = 0; k < 200 && relation_q.size() > 0; k++)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
		if (relation_q.size() > 0) begin
			$error("%0d relations never returned", relation_q.size());
			errors += relation_q.size();
			relation_q.delete();
		end
	endtask

	always @(negedge clk) begin
		sphere_t issue;
		if (arst_n && (!start || took)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sphere_q.size() > 0) begin
				issue = sphere_q.pop_front();
				center_x <= issue.cx;
				center_y <= issue.cy;
				center_z <= issue.cz;
				radius <= issue.rad;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 60);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		relation_t want;
		took <= arst_n && start && !busy;
		if (arst_n && done) begin
			if (relation_q.size() == 0) begin
				$error("relation %0d with no sphere pending", relation);
				errors++;
			end else begin
				want = relation_q.pop_front();
				if (relation !== want) begin
					$error("relation mismatch: expected %0d, actual %0d", want, relation);
					errors++;
				end
			end
			if (relation < 3)
				n_rel[relation]++;
		end
		if (arst_n && start && !busy) begin
			relation_q.push_back(classify_sphere('{center_x, center_y, center_z, radius}));
			n_spheres++;
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// planes at reset are all zero; writes past the last plane must be dropped
		cfg_write(IDX_UNUSED_LO, '1);
		cfg_write(IDX_UNUSED_HI, pack_plane(NORM_ONE, NORM_ONE, NORM_ONE, FIELD_MAX));
		@(posedge clk);
		add_sphere(0, 0, 0, 0);
		add_sphere(0, 0, 0, 1);
		add_sphere(32767, 32767, 32767, 32767);
		add_sphere(-32768, -32768, -32768, 0);
		add_random(40, 32767);
		settle();

		// axis box, 1600 units half width: tangent and zero-radius edges
		load_frustum(box_frustum(16'd1600));
		add_sphere(-1632, 0, 0, 32);
		add_sphere(-1633, 0, 0, 32);
		add_sphere(-1568, 0, 0, 32);
		add_sphere(-1569, 0, 0, 32);
		add_sphere(0, 1632, 0, 32);
		add_sphere(0, 1633, 0, 32);
		add_sphere(0, 0, 1568, 32);
		add_sphere(0, 0, 1569, 32);
		add_sphere(-1600, 0, 0, 0);
		add_sphere(-1601, 0, 0, 0);
		add_sphere(0, 0, 0, 0);
		add_random(260, 3000);
		settle();

		load_frustum(rand_frustum(16384, 4000, 1'b0));
		add_random(140, 3000);
		settle();
		load_frustum(rand_frustum(16384, 4000, 1'b0));
		add_random(140, 3000);
		settle();

		load_frustum(rand_frustum(0, 0, 1'b1));
		add_random(150, 32767);
		settle();

		load_frustum(flat_frustum(FIELD_MAX));
		add_sphere(32767, 32767, 32767, 32767);
		add_sphere(-32768, -32768, -32768, 0);
		add_random(70, 32767);
		settle();
		load_frustum(flat_frustum(FIELD_MIN));
		add_sphere(32767, 32767, 32767, 32767);
		add_sphere(-32768, -32768, -32768, 0);
		add_random(70, 32767);
		settle();

		load_frustum(box_frustum(16'd400));
		add_random(260, 800);
		settle();

		$display("%0d spheres over %0d plane sets plus reset planes", n_spheres, n_settings);
		$display("relations seen: %0d inside, %0d partly, %0d outside",
			n_rel[0], n_rel[1], n_rel[2]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sfc_pkg.sv
rtl/sfc_plane_regs.sv
rtl/sfc_plane_unit.sv
rtl/sphere_frustum_classifier.sv
verif/tb.sv
